>>> src/tlk_pkg.sv
package tlk_pkg;

    // Coordinate format.
    localparam int COORD_WIDTH = 16;
    localparam int COORD_FRAC  = 8;
    localparam int OUT_FRAC    = 16;
    localparam int OUT_SHIFT   = OUT_FRAC - COORD_FRAC;

    // Widths through the datapath.
    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int COF3_W  = COF_W + 2;
    localparam int DPART_W = EDGE_W + COF_W;
    localparam int DET_W   = DPART_W + 2;
    localparam int DET6_W  = DET_W + 3;

    // Cofactor products are split into a high and a low part.
    localparam int LO_W    = (COF3_W + 1) / 2;
    localparam int HI_W    = COF3_W - LO_W;
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W + 1;
    localparam int LL_W    = 2 * LO_W;
    localparam int DPROD_W = 2 * COF3_W;
    localparam int DOT_W   = DPROD_W + 2;

    // Divider operands and quotient.
    localparam int NUM_W   = DOT_W + OUT_SHIFT;
    localparam int DEN_W   = DET6_W;
    localparam int QW      = 32;
    localparam int CMP_W   = DEN_W + QW;
    localparam int DIV_LAT = QW + 2;

    localparam int NUM_ENTRIES = 10;
    localparam int PRE_STAGES  = 7;
    localparam int PIPE_LAT    = PRE_STAGES + DIV_LAT;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [QW-1:0]          t_entry;

    localparam int PAIR_A [NUM_ENTRIES] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int PAIR_B [NUM_ENTRIES] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

endpackage

>>> src/tlk_div.sv
module tlk_div import tlk_pkg::*; (
    input  logic               i_clk,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic               i_neg,
    output t_entry             o_q
);

    logic [NUM_W-1:0] r_rem [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [QW-1:0]    r_q   [QW+1];
    logic             r_neg [QW+1];
    logic             r_sat [QW+1];
    t_entry           r_out;

    // A quotient of 2^32 or more can only saturate.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_neg;
        r_sat[0] <= CMP_W'(i_num) >= (CMP_W'(i_den) << QW);
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [CMP_W-1:0] n_sub;
        logic [CMP_W-1:0] n_trial;
        logic             n_take;

        always_comb begin
            n_sub   = CMP_W'(r_den[k-1]) << B;
            n_take  = CMP_W'(r_rem[k-1]) >= n_sub;
            n_trial = CMP_W'(r_rem[k-1]) - n_sub;
        end

        always_ff @(posedge i_clk) begin
            r_q[k]   <= r_q[k-1] | (n_take ? (QW'(1) << B) : QW'(0));
            r_neg[k] <= r_neg[k-1];
            r_sat[k] <= r_sat[k-1];
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_take ? n_trial[NUM_W-1:0] : r_rem[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_neg[QW]) begin
            if (r_sat[QW] || r_q[QW] > {1'b1, {(QW-1){1'b0}}}) begin
                r_out <= {1'b1, {(QW-1){1'b0}}};
            end else begin
                r_out <= -$signed(r_q[QW]);
            end
        end else begin
            if (r_sat[QW] || r_q[QW][QW-1]) begin
                r_out <= {1'b0, {(QW-1){1'b1}}};
            end else begin
                r_out <= $signed(r_q[QW]);
            end
        end
    end

    assign o_q = r_out;

endmodule

>>> src/tet_laplace_element_stiffness.sv
// A result strobes on o_valid once start has passed through the r_vld shift register and r_out_vld.
// Throughput: one tetrahedron per cycle; busy is always low.
// Most of the depth lies in the ten 32-stage restoring dividers, one quotient bit per stage.
// Reset (synchronous, active low) clears only the valid pipeline; no result follows it.
// The receiver cannot stall: every result is shown for exactly one cycle.
module tet_laplace_element_stiffness import tlk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_coord i_p0_x,
    input  t_coord i_p0_y,
    input  t_coord i_p0_z,
    input  t_coord i_p1_x,
    input  t_coord i_p1_y,
    input  t_coord i_p1_z,
    input  t_coord i_p2_x,
    input  t_coord i_p2_y,
    input  t_coord i_p2_z,
    input  t_coord i_p3_x,
    input  t_coord i_p3_y,
    input  t_coord i_p3_z,
    output logic   o_valid,
    output t_entry o_k_00,
    output t_entry o_k_01,
    output t_entry o_k_02,
    output t_entry o_k_03,
    output t_entry o_k_11,
    output t_entry o_k_12,
    output t_entry o_k_13,
    output t_entry o_k_22,
    output t_entry o_k_23,
    output t_entry o_k_33,
    output logic   o_degenerate
);

    t_coord pt [4][3];

    logic signed [EDGE_W-1:0]  r_e    [3][3];
    logic signed [PROD_W-1:0]  r_cp   [3][3][2];
    logic signed [EDGE_W-1:0]  r_e0_2 [3];
    logic signed [EDGE_W-1:0]  r_e0_3 [3];
    logic signed [COF3_W-1:0]  n_c    [3][4];
    logic signed [COF3_W-1:0]  r_c    [3][4];
    logic signed [DPART_W-1:0] r_dp   [3];
    logic signed [HH_W-1:0]    r_hh   [NUM_ENTRIES][3];
    logic signed [HL_W-1:0]    r_hl   [NUM_ENTRIES][3];
    logic signed [HL_W-1:0]    r_lh   [NUM_ENTRIES][3];
    logic        [LL_W-1:0]    r_ll   [NUM_ENTRIES][3];
    logic signed [DET_W-1:0]   r_det;
    logic signed [DPROD_W-1:0] r_prod [NUM_ENTRIES][3];
    logic signed [DET6_W-1:0]  r_det6;
    logic signed [DOT_W-1:0]   r_dot  [NUM_ENTRIES];
    logic        [NUM_W-1:0]   r_num  [NUM_ENTRIES];
    logic        [DEN_W-1:0]   r_den;
    logic                      r_neg  [NUM_ENTRIES];
    logic                      r_deg;
    logic                      r_deg_dly [DIV_LAT];
    logic        [PIPE_LAT-1:0] r_vld;
    t_entry                    q      [NUM_ENTRIES];
    t_entry                    r_k    [NUM_ENTRIES];
    logic                      r_out_vld;
    logic                      r_out_deg;

    assign pt[0][0] = i_p0_x;
    assign pt[0][1] = i_p0_y;
    assign pt[0][2] = i_p0_z;
    assign pt[1][0] = i_p1_x;
    assign pt[1][1] = i_p1_y;
    assign pt[1][2] = i_p1_z;
    assign pt[2][0] = i_p2_x;
    assign pt[2][1] = i_p2_y;
    assign pt[2][2] = i_p2_z;
    assign pt[3][0] = i_p3_x;
    assign pt[3][1] = i_p3_y;
    assign pt[3][2] = i_p3_z;

    assign busy = 1'b0;

    // Edges from corner 3, indexed by axis and then by corner.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int a = 0; a < 3; a++) begin
                r_e[r][a] <= EDGE_W'(pt[a][r]) - EDGE_W'(pt[3][r]);
            end
        end
    end

    // The two products of each cofactor.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int a = 0; a < 3; a++) begin
                r_cp[r][a][0] <= r_e[(r+1)%3][(a+1)%3] * r_e[(r+2)%3][(a+2)%3];
                r_cp[r][a][1] <= r_e[(r+1)%3][(a+2)%3] * r_e[(r+2)%3][(a+1)%3];
            end
            r_e0_2[r] <= r_e[0][r];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int a = 0; a < 3; a++) begin
                n_c[r][a] = COF3_W'(r_cp[r][a][0]) - COF3_W'(r_cp[r][a][1]);
            end
            n_c[r][3] = -(n_c[r][0] + n_c[r][1] + n_c[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_e0_3 <= r_e0_2;
    end

    // Determinant terms and the split partial products of every dot product.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_dp[a] <= r_e0_3[a] * $signed(r_c[0][a][COF_W-1:0]);
        end
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            for (int r = 0; r < 3; r++) begin
                r_hh[k][r] <= $signed(r_c[r][PAIR_A[k]][COF3_W-1:LO_W])
                            * $signed(r_c[r][PAIR_B[k]][COF3_W-1:LO_W]);
                r_hl[k][r] <= $signed(r_c[r][PAIR_A[k]][COF3_W-1:LO_W])
                            * $signed({1'b0, r_c[r][PAIR_B[k]][LO_W-1:0]});
                r_lh[k][r] <= $signed(r_c[r][PAIR_B[k]][COF3_W-1:LO_W])
                            * $signed({1'b0, r_c[r][PAIR_A[k]][LO_W-1:0]});
                r_ll[k][r] <= r_c[r][PAIR_A[k]][LO_W-1:0] * r_c[r][PAIR_B[k]][LO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_det <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[k][r] <= (DPROD_W'(r_hh[k][r]) <<< (2 * LO_W))
                              + ((DPROD_W'(r_hl[k][r]) + DPROD_W'(r_lh[k][r])) <<< LO_W)
                              + $signed(DPROD_W'(r_ll[k][r]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_det6 <= (DET6_W'(r_det) <<< 1) + (DET6_W'(r_det) <<< 2);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            r_dot[k] <= DOT_W'(r_prod[k][0]) + DOT_W'(r_prod[k][1]) + DOT_W'(r_prod[k][2]);
        end
    end

    // Magnitudes and signs for the unsigned dividers.
    always_ff @(posedge i_clk) begin
        r_den <= r_det6[DET6_W-1] ? DEN_W'(-r_det6) : DEN_W'(r_det6);
        r_deg <= (r_det6 == '0);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            r_num[k] <= (r_dot[k][DOT_W-1] ? NUM_W'(DOT_W'(-r_dot[k])) : NUM_W'(r_dot[k]))
                        << OUT_SHIFT;
            r_neg[k] <= r_dot[k][DOT_W-1] ^ r_det6[DET6_W-1];
        end
    end

    for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_div
        tlk_div u_div (
            .i_clk (i_clk),
            .i_num (r_num[k]),
            .i_den (r_den),
            .i_neg (r_neg[k]),
            .o_q   (q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_deg_dly[0] <= r_deg;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_deg_dly[i] <= r_deg_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[PIPE_LAT-2:0], start};
            r_out_vld <= r_vld[PIPE_LAT-1];
        end
    end

    // A flat tetrahedron gives all-zero entries.
    always_ff @(posedge i_clk) begin
        r_out_deg <= r_deg_dly[DIV_LAT-1];
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            r_k[k] <= r_deg_dly[DIV_LAT-1] ? '0 : q[k];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_degenerate = r_out_deg;
    assign o_k_00       = r_k[0];
    assign o_k_01       = r_k[1];
    assign o_k_02       = r_k[2];
    assign o_k_03       = r_k[3];
    assign o_k_11       = r_k[4];
    assign o_k_12       = r_k[5];
    assign o_k_13       = r_k[6];
    assign o_k_22       = r_k[7];
    assign o_k_23       = r_k[8];
    assign o_k_33       = r_k[9];

endmodule
